@@ design/khwm_pkg.sv @@
`default_nettype none

package khwm_pkg;

    localparam int NUM_TARGETS = 64;
    localparam int NUM_PAIRS   = (NUM_TARGETS + 1) / 2;
    localparam int PAIR_W      = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int IDX_W       = PAIR_W + 1;
    localparam int CNT_W       = $clog2(NUM_TARGETS + 1);

    localparam logic [1:0] ACT_CLEAR    = 2'd0;
    localparam logic [1:0] ACT_TGT_BASE = 2'd1;
    localparam logic [1:0] ACT_NEW_SEQ  = 2'd2;
    localparam logic [1:0] ACT_SEQ_BASE = 2'd3;

    localparam logic [1:0] CFG_TARGET_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_MAX_MISMATCHES = 2'd1;
    localparam logic [1:0] CFG_FILTER_AC      = 2'd2;
    localparam logic [1:0] CFG_FILTER_GT      = 2'd3;

    localparam logic [5:0] MAX_LEN      = 6'd32;
    localparam logic [5:0] LOAD_SAT     = 6'd33;
    localparam logic [5:0] RST_TLEN     = 6'd23;
    localparam logic [5:0] RST_MAX_MM   = 6'd4;

    typedef logic [PAIR_W-1:0] t_pair;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] base_char;
        logic       target_end;
    } t_in;

    typedef struct packed {
        logic [5:0]  target_index;
        logic [15:0] sequence_id;
        logic [31:0] position;
        logic [5:0]  similarity;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [63:0] win_ac;
        logic [63:0] win_gt;
        logic [15:0] seq_id;
        logic [31:0] pos;
        logic [5:0]  thr;
        t_cnt        count;
    } t_job;

    typedef struct packed {
        logic         we;
        logic         bank;
        t_pair        addr;
        logic [127:0] data;
    } t_tgt_wr;

    typedef struct packed {
        logic  re;
        t_pair addr;
    } t_rd;

    // {a, c, g, t}
    function automatic logic [3:0] base_code(input logic [7:0] ch);
        logic [3:0] r;
        r = 4'b0000;
        case (ch)
            8'h41, 8'h61: r = 4'b1000;
            8'h43, 8'h63: r = 4'b0100;
            8'h47, 8'h67: r = 4'b0010;
            8'h54, 8'h74: r = 4'b0001;
            default:      r = 4'b0000;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] shift_base(input logic [63:0] w, input logic hi,
                                               input logic lo);
        return {w[62:32], hi, w[30:0], lo};
    endfunction

    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int k = 0; k < 64; k++) begin
            n = n + 7'(v[k]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ design/khwm_ram.sv @@
`default_nettype none

module khwm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/khwm_queue.sv @@
`default_nettype none

module khwm_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire khwm_pkg::t_job  i_data,
    input  wire logic            i_pop,
    output khwm_pkg::t_job       o_data,
    output logic                 o_valid,
    output logic                 o_full
);

    khwm_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/khwm_front.sv @@
`default_nettype none

module khwm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire khwm_pkg::t_in     i_in,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [63:0]       i_cfg_wdata,
    input  wire logic              i_back_busy,
    input  wire logic              i_q_full,
    output logic                   o_job_push,
    output khwm_pkg::t_job         o_job,
    output khwm_pkg::t_tgt_wr      o_tgt_wr
);

    logic [5:0]      r_tlen;
    logic [5:0]      r_max_mm;
    logic [63:0]     r_filter_ac;
    logic [63:0]     r_filter_gt;
    khwm_pkg::t_cnt  r_tcount;
    logic [63:0]     r_load_ac;
    logic [63:0]     r_load_gt;
    logic [5:0]      r_load_len;
    logic [63:0]     r_win_ac;
    logic [63:0]     r_win_gt;
    logic [31:0]     r_base_pos;
    logic [15:0]     r_seq_cnt;

    logic            accept;
    logic [3:0]      code;
    logic [63:0]     n_load_ac;
    logic [63:0]     n_load_gt;
    logic [5:0]      n_load_len;
    logic [63:0]     n_win_ac;
    logic [63:0]     n_win_gt;
    logic [5:0]      eff_len;
    logic            pos_ok;
    logic            mm_ok;
    logic            filt_ok;
    logic            tgt_store;
    khwm_pkg::t_idx  wr_idx;

    assign o_in_ready = !i_q_full &&
                        !((i_in.action == khwm_pkg::ACT_TGT_BASE) && i_in.target_end &&
                          i_back_busy);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        code       = khwm_pkg::base_code(i_in.base_char);
        n_load_ac  = khwm_pkg::shift_base(r_load_ac, code[3], code[2]);
        n_load_gt  = khwm_pkg::shift_base(r_load_gt, code[1], code[0]);
        n_win_ac   = khwm_pkg::shift_base(r_win_ac, code[3], code[2]);
        n_win_gt   = khwm_pkg::shift_base(r_win_gt, code[1], code[0]);
        n_load_len = (r_load_len < khwm_pkg::LOAD_SAT) ? r_load_len + 6'd1 : r_load_len;

        if (r_tlen == 6'd0) begin
            eff_len = 6'd1;
        end else if (r_tlen > khwm_pkg::MAX_LEN) begin
            eff_len = khwm_pkg::MAX_LEN;
        end else begin
            eff_len = r_tlen;
        end
        pos_ok  = r_base_pos >= ({26'd0, eff_len} - 32'd1);
        mm_ok   = r_max_mm <= eff_len;
        // window covers every filter bit
        filt_ok = (((n_win_ac & r_filter_ac) | (n_win_gt & r_filter_gt)) ==
                   (r_filter_ac | r_filter_gt));

        o_job.win_ac = n_win_ac;
        o_job.win_gt = n_win_gt;
        o_job.seq_id = r_seq_cnt;
        o_job.pos    = r_base_pos;
        o_job.thr    = eff_len - r_max_mm;
        o_job.count  = r_tcount;

        o_job_push = accept && (i_in.action == khwm_pkg::ACT_SEQ_BASE) && pos_ok && mm_ok &&
                     filt_ok && (r_tcount != khwm_pkg::t_cnt'(0));

        tgt_store = accept && (i_in.action == khwm_pkg::ACT_TGT_BASE) && i_in.target_end &&
                    (r_tcount < khwm_pkg::t_cnt'(khwm_pkg::NUM_TARGETS));
        wr_idx    = khwm_pkg::t_idx'(r_tcount);

        o_tgt_wr.we   = tgt_store;
        o_tgt_wr.bank = wr_idx[0];
        o_tgt_wr.addr = khwm_pkg::t_pair'(wr_idx >> 1);
        o_tgt_wr.data = (n_load_len > khwm_pkg::MAX_LEN) ? 128'd0 : {n_load_ac, n_load_gt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen      <= khwm_pkg::RST_TLEN;
            r_max_mm    <= khwm_pkg::RST_MAX_MM;
            r_filter_ac <= 64'd0;
            r_filter_gt <= 64'd0;
            r_tcount    <= '0;
            r_load_ac   <= 64'd0;
            r_load_gt   <= 64'd0;
            r_load_len  <= 6'd0;
            r_win_ac    <= 64'd0;
            r_win_gt    <= 64'd0;
            r_base_pos  <= 32'd0;
            r_seq_cnt   <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    khwm_pkg::CFG_TARGET_LENGTH:  r_tlen      <= i_cfg_wdata[5:0];
                    khwm_pkg::CFG_MAX_MISMATCHES: r_max_mm    <= i_cfg_wdata[5:0];
                    khwm_pkg::CFG_FILTER_AC:      r_filter_ac <= i_cfg_wdata;
                    khwm_pkg::CFG_FILTER_GT:      r_filter_gt <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                case (i_in.action)
                    khwm_pkg::ACT_CLEAR: begin
                        r_tcount   <= '0;
                        r_load_ac  <= 64'd0;
                        r_load_gt  <= 64'd0;
                        r_load_len <= 6'd0;
                    end
                    khwm_pkg::ACT_TGT_BASE: begin
                        if (i_in.target_end) begin
                            r_load_ac  <= 64'd0;
                            r_load_gt  <= 64'd0;
                            r_load_len <= 6'd0;
                            if (tgt_store) begin
                                r_tcount <= r_tcount + khwm_pkg::t_cnt'(1);
                            end
                        end else begin
                            r_load_ac  <= n_load_ac;
                            r_load_gt  <= n_load_gt;
                            r_load_len <= n_load_len;
                        end
                    end
                    khwm_pkg::ACT_NEW_SEQ: begin
                        r_win_ac   <= 64'd0;
                        r_win_gt   <= 64'd0;
                        r_base_pos <= 32'd0;
                        if (r_seq_cnt != 16'hFFFF) begin
                            r_seq_cnt <= r_seq_cnt + 16'd1;
                        end
                    end
                    default: begin
                        r_win_ac <= n_win_ac;
                        r_win_gt <= n_win_gt;
                        if (r_base_pos != 32'hFFFF_FFFF) begin
                            r_base_pos <= r_base_pos + 32'd1;
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ design/khwm_back.sv @@
`default_nettype none

module khwm_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_job_valid,
    input  wire khwm_pkg::t_job  i_job,
    output logic                 o_job_pop,
    output logic                 o_busy,
    output khwm_pkg::t_rd        o_rd,
    input  wire logic [127:0]    i_rdata0,
    input  wire logic [127:0]    i_rdata1,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output khwm_pkg::t_out       o_out
);

    khwm_pkg::t_job  r_job;
    logic            r_act;
    khwm_pkg::t_pair r_pair;
    khwm_pkg::t_pair r_last_pair;
    logic            r_s1_v;
    khwm_pkg::t_pair r_s1_pair;
    logic [1:0]      r_s2_hit;
    logic [5:0]      r_s2_sim0;
    logic [5:0]      r_s2_sim1;
    khwm_pkg::t_pair r_s2_pair;
    logic            r_pend_v;
    khwm_pkg::t_out  r_pend;
    logic            r_out_v;
    khwm_pkg::t_out  r_out;

    logic            out_free;
    logic            take;
    logic            sel;
    logic [1:0]      take_mask;
    logic            s2_free;
    logic            adv;
    logic            flush;
    logic            start;
    khwm_pkg::t_idx  idx0;
    khwm_pkg::t_idx  idx1;
    khwm_pkg::t_idx  sel_idx;
    logic [6:0]      sim0;
    logic [6:0]      sim1;
    logic [1:0]      hit;
    khwm_pkg::t_cnt  cnt_m1;
    khwm_pkg::t_out  hit_res;
    khwm_pkg::t_out  pend_last;

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    assign o_busy      = r_act || i_job_valid;

    always_comb begin
        out_free  = !r_out_v || i_out_ready;
        sel       = !r_s2_hit[0];
        take      = (r_s2_hit != 2'b00) && (!r_pend_v || out_free);
        take_mask = take ? (sel ? 2'b10 : 2'b01) : 2'b00;
        s2_free   = (r_s2_hit & ~take_mask) == 2'b00;
        adv       = s2_free;
        flush     = !r_act && !r_s1_v && (r_s2_hit == 2'b00) && r_pend_v && out_free;
        start     = !r_act && !r_s1_v && (r_s2_hit == 2'b00) && !r_pend_v && i_job_valid;
        o_job_pop = start;

        o_rd.re   = r_act && adv;
        o_rd.addr = r_pair;

        idx0 = {r_s1_pair, 1'b0};
        idx1 = {r_s1_pair, 1'b1};
        sim0 = khwm_pkg::popcount64((r_job.win_ac & i_rdata0[127:64]) |
                                    (r_job.win_gt & i_rdata0[63:0]));
        sim1 = khwm_pkg::popcount64((r_job.win_ac & i_rdata1[127:64]) |
                                    (r_job.win_gt & i_rdata1[63:0]));
        hit[0] = (khwm_pkg::t_cnt'(idx0) < r_job.count) && (sim0 >= {1'b0, r_job.thr});
        hit[1] = (khwm_pkg::t_cnt'(idx1) < r_job.count) && (sim1 >= {1'b0, r_job.thr});

        cnt_m1 = i_job.count - khwm_pkg::t_cnt'(1);

        sel_idx              = {r_s2_pair, sel};
        hit_res.target_index = 6'(sel_idx);
        hit_res.sequence_id  = r_job.seq_id;
        hit_res.position     = r_job.pos;
        hit_res.similarity   = sel ? r_s2_sim1 : r_s2_sim0;
        hit_res.last         = 1'b0;

        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job       <= i_job;
            r_last_pair <= khwm_pkg::t_pair'(cnt_m1 >> 1);
        end
        if (adv && r_act) begin
            r_s1_pair <= r_pair;
        end
        if (adv) begin
            r_s2_sim0 <= 6'(sim0);
            r_s2_sim1 <= 6'(sim1);
            r_s2_pair <= r_s1_pair;
        end
        if (take) begin
            r_pend <= hit_res;
        end
        if (take && r_pend_v) begin
            r_out <= r_pend;
        end else if (flush) begin
            r_out <= pend_last;
        end

        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_pair   <= '0;
            r_s1_v   <= 1'b0;
            r_s2_hit <= 2'b00;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (start) begin
                r_act  <= 1'b1;
                r_pair <= '0;
            end else if (adv && r_act) begin
                r_pair <= r_pair + khwm_pkg::t_pair'(1);
                if (r_pair == r_last_pair) begin
                    r_act <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_v   <= r_act;
                r_s2_hit <= r_s1_v ? hit : 2'b00;
            end else begin
                r_s2_hit <= r_s2_hit & ~take_mask;
            end
            if (take) begin
                r_pend_v <= 1'b1;
            end else if (flush) begin
                r_pend_v <= 1'b0;
            end
            if ((take && r_pend_v) || flush) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/kmer_hamming_window_matcher.sv @@
// sequence base: a scan reads n = ceil(target_count / 2) rows, two targets per cycle from the
// even and odd target memory banks, stalling while a row's second match or a result waits on
// the output; a two-entry job queue lets bases be taken meanwhile; other transactions are
// accepted whenever the job queue is not full; a target completion also waits until queued
// scans read all rows
// synchronous active-low reset clears control state; target memories are not cleared
`default_nettype none

module kmer_hamming_window_matcher (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire khwm_pkg::t_in    i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output khwm_pkg::t_out        o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [63:0]      i_cfg_wdata
);

    logic               job_push;
    khwm_pkg::t_job     job_in;
    khwm_pkg::t_job     job_out;
    logic               job_valid;
    logic               job_pop;
    logic               q_full;
    logic               back_busy;
    khwm_pkg::t_tgt_wr  tgt_wr;
    khwm_pkg::t_rd      rd;
    logic [127:0]       rdata0;
    logic [127:0]       rdata1;

    khwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_back_busy (back_busy),
        .i_q_full    (q_full),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .o_tgt_wr    (tgt_wr)
    );

    khwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_valid (job_valid),
        .o_full  (q_full)
    );

    khwm_ram #(
        .WIDTH (128),
        .DEPTH (khwm_pkg::NUM_PAIRS)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (tgt_wr.we && !tgt_wr.bank),
        .i_waddr (tgt_wr.addr),
        .i_wdata (tgt_wr.data),
        .i_re    (rd.re),
        .i_raddr (rd.addr),
        .o_rdata (rdata0)
    );

    khwm_ram #(
        .WIDTH (128),
        .DEPTH (khwm_pkg::NUM_PAIRS)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (tgt_wr.we && tgt_wr.bank),
        .i_waddr (tgt_wr.addr),
        .i_wdata (tgt_wr.data),
        .i_re    (rd.re),
        .i_raddr (rd.addr),
        .o_rdata (rdata1)
    );

    khwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_busy      (back_busy),
        .o_rd        (rd),
        .i_rdata0    (rdata0),
        .i_rdata1    (rdata1),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
